>>> rtl/rgba_alpha_blend_assert.svh
// Assertion macros; clk and rst_n must be visible where they are used.
`ifndef RGBA_ALPHA_BLEND_ASSERT_SVH
`define RGBA_ALPHA_BLEND_ASSERT_SVH

`define RAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rab assertion failed");

`define RAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rab assertion failed");

`endif

>>> rtl/rab_pkg.sv
package rab_pkg;

  localparam int FRAC_BITS = 15;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int FIELD_W   = 16;
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 3;

  typedef logic [VAL_W-1:0]   val_t;
  typedef val_t [3:0]         quad_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam val_t ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int CH_A = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO,
    MODE_BLEND,
    MODE_OVERLAY,
    MODE_OPAQUE,
    MODE_BLACK_GREEN,
    MODE_WHITE_GREEN
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE,
    REG_FACTOR,
    REG_BASE_SRC,
    REG_TOP_SRC,
    REG_TINT_R,
    REG_TINT_G,
    REG_TINT_B,
    REG_TINT_A
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    field_t            factor;
    logic              base_src;
    logic              top_src;
    field_t [3:0]      tint;
  } cfg_t;

  typedef struct packed {
    quad_t             base;
    quad_t             top;
    val_t              b;
    logic [MODE_W-1:0] mode;
    logic              last;
  } s0_t;

  typedef struct packed {
    quad_t             base;
    quad_t             top;
    val_t              t;
    val_t              k;
    val_t              g;
    logic [MODE_W-1:0] mode;
    logic              last;
  } s1_t;

  typedef struct packed {
    quad_t             p0;
    quad_t             p1;
    quad_t             base;
    logic [MODE_W-1:0] mode;
    logic              last;
  } s2_t;

  function automatic val_t clamp_f(field_t v);
    if ({{VAL_W{1'b0}}, v} > {{FIELD_W{1'b0}}, ONE}) begin
      return ONE;
    end
    return VAL_W'(v);
  endfunction

  function automatic val_t clamp_sum(logic [VAL_W:0] v);
    if (v > {1'b0, ONE}) begin
      return ONE;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic val_t fmul(val_t a, val_t b);
    logic [2*VAL_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS +: VAL_W];
  endfunction

  function automatic field_t to_field(val_t v);
    return FIELD_W'(v);
  endfunction

endpackage

>>> rtl/rab_if.sv
interface rab_in_if import rab_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t base_red;
  field_t base_green;
  field_t base_blue;
  field_t base_alpha;
  field_t top_red;
  field_t top_green;
  field_t top_blue;
  field_t top_alpha;
  logic   in_last;

  modport source (
    output valid, base_red, base_green, base_blue, base_alpha,
           top_red, top_green, top_blue, top_alpha, in_last,
    input  ready
  );
  modport sink (
    input  valid, base_red, base_green, base_blue, base_alpha,
           top_red, top_green, top_blue, top_alpha, in_last,
    output ready
  );
endinterface

interface rab_out_if import rab_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t out_red;
  field_t out_green;
  field_t out_blue;
  field_t out_alpha;
  logic   out_last;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, out_last,
    output ready
  );
endinterface

>>> rtl/rgba_alpha_blend.sv
// Four register stages from input transfer to result valid: prep, weight, multiply, sum.
// Throughput: one pixel per cycle; the four register stages advance together and
// hold while the result register waits for out ready.
// Reset: synchronous active-low rst_n clears stage valids and loads the
// configuration registers with their defaults (blend mode, factor 1.0, both streams on).
module rgba_alpha_blend import rab_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  field_t            cfg_data,
  rab_in_if.sink            in_pix,
  rab_out_if.source         out_pix
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic en;
  logic s0_valid;
  s0_t  s0;
  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:     cfg_nxt.mode     = cfg_data[MODE_W-1:0];
        REG_FACTOR:   cfg_nxt.factor   = cfg_data;
        REG_BASE_SRC: cfg_nxt.base_src = cfg_data[0];
        REG_TOP_SRC:  cfg_nxt.top_src  = cfg_data[0];
        REG_TINT_R:   cfg_nxt.tint[CH_R] = cfg_data;
        REG_TINT_G:   cfg_nxt.tint[CH_G] = cfg_data;
        REG_TINT_B:   cfg_nxt.tint[CH_B] = cfg_data;
        REG_TINT_A:   cfg_nxt.tint[CH_A] = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_BLEND;
      cfg_r.factor   <= to_field(ONE);
      cfg_r.base_src <= 1'b1;
      cfg_r.top_src  <= 1'b1;
      cfg_r.tint     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_pix.ready = en;

  rab_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .in_pix     (in_pix),
    .s0_valid_r (s0_valid),
    .s0_r       (s0)
  );

  rab_weight u_weight (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .s0_valid   (s0_valid),
    .s0         (s0),
    .s1_valid_r (s1_valid),
    .s1_r       (s1)
  );

  rab_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s2_valid_r (s2_valid),
    .s2_r       (s2)
  );

  rab_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2       (s2),
    .en       (en),
    .out_pix  (out_pix)
  );

endmodule

>>> rtl/rab_prep.sv
module rab_prep import rab_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  cfg_t       cfg,
  rab_in_if.sink     in_pix,
  output logic       s0_valid_r,
  output s0_t        s0_r
);

  s0_t    s0_nxt;
  quad_t  base_raw;
  quad_t  top_raw;

  always_comb begin
    base_raw[CH_R] = clamp_f(in_pix.base_red);
    base_raw[CH_G] = clamp_f(in_pix.base_green);
    base_raw[CH_B] = clamp_f(in_pix.base_blue);
    base_raw[CH_A] = clamp_f(in_pix.base_alpha);
    top_raw[CH_R]  = clamp_f(in_pix.top_red);
    top_raw[CH_G]  = clamp_f(in_pix.top_green);
    top_raw[CH_B]  = clamp_f(in_pix.top_blue);
    top_raw[CH_A]  = clamp_f(in_pix.top_alpha);
    for (int i = 0; i < 4; i++) begin
      s0_nxt.base[i] = cfg.base_src ? base_raw[i] : '0;
      s0_nxt.top[i]  = cfg.top_src ? top_raw[i] : clamp_f(cfg.tint[i]);
    end
    s0_nxt.b    = clamp_f(cfg.factor);
    s0_nxt.mode = cfg.mode;
    s0_nxt.last = in_pix.in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

endmodule

>>> rtl/rab_weight.sv
module rab_weight import rab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic s0_valid,
  input  s0_t  s0,
  output logic s1_valid_r,
  output s1_t  s1_r
);

  s1_t  s1_nxt;
  val_t g_sel;

  always_comb begin
    s1_nxt.base = s0.base;
    s1_nxt.top  = s0.top;
    s1_nxt.mode = s0.mode;
    s1_nxt.last = s0.last;
    s1_nxt.t    = (s0.mode == MODE_BLEND) ? s0.b : fmul(s0.top[CH_A], s0.b);
    s1_nxt.k    = ONE - fmul(ONE - s0.top[CH_A], s0.b);
    g_sel       = (s0.mode == MODE_BLACK_GREEN) ? ONE - s0.base[CH_G] : s0.base[CH_G];
    s1_nxt.g    = fmul(g_sel, s0.base[CH_A]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

>>> rtl/rab_mul.sv
module rab_mul import rab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic s1_valid,
  input  s1_t  s1,
  output logic s2_valid_r,
  output s2_t  s2_r
);

  s2_t  s2_nxt;
  val_t ax;
  val_t ay;

  always_comb begin
    case (s1.mode)
      MODE_BLEND: begin
        ax = ONE - s1.t;
        ay = s1.base[CH_A];
      end
      MODE_OVERLAY: begin
        ax = ONE - s1.base[CH_A];
        ay = s1.t;
      end
      MODE_OPAQUE: begin
        ax = s1.base[CH_A];
        ay = s1.k;
      end
      default: begin
        ax = s1.g;
        ay = s1.k;
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      s2_nxt.p0[c] = fmul(ONE - s1.t, s1.base[c]);
      s2_nxt.p1[c] = fmul(s1.t, s1.top[c]);
    end
    s2_nxt.p0[CH_A] = fmul(ax, ay);
    s2_nxt.p1[CH_A] = fmul(s1.t, s1.top[CH_A]);
    s2_nxt.base     = s1.base;
    s2_nxt.mode     = s1.mode;
    s2_nxt.last     = s1.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

>>> rtl/rab_sum.sv
module rab_sum import rab_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s2_valid,
  input  s2_t        s2,
  output logic       en,
  rab_out_if.source  out_pix
);

  logic   out_valid_r;
  quad_t  res_r;
  quad_t  res_nxt;
  quad_t  sum;
  logic   last_r;

  assign en = !out_valid_r || out_pix.ready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = clamp_sum({1'b0, s2.p0[i]} + {1'b0, s2.p1[i]});
    end
    res_nxt = s2.base;
    case (s2.mode) inside
      MODE_BLEND: begin
        res_nxt = sum;
      end
      MODE_OVERLAY: begin
        res_nxt       = sum;
        res_nxt[CH_A] = clamp_sum({1'b0, s2.base[CH_A]} + {1'b0, s2.p0[CH_A]});
      end
      MODE_OPAQUE, MODE_BLACK_GREEN, MODE_WHITE_GREEN: begin
        res_nxt       = sum;
        res_nxt[CH_A] = s2.p0[CH_A];
      end
      default: begin
        res_nxt = s2.base;
      end
    endcase
    if (res_nxt[CH_A] == '0) begin
      res_nxt[CH_R] = '0;
      res_nxt[CH_G] = '0;
      res_nxt[CH_B] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      last_r <= s2.last;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.out_red   = to_field(res_r[CH_R]);
  assign out_pix.out_green = to_field(res_r[CH_G]);
  assign out_pix.out_blue  = to_field(res_r[CH_B]);
  assign out_pix.out_alpha = to_field(res_r[CH_A]);
  assign out_pix.out_last  = last_r;

endmodule

>>> rtl/rab_checker.sv
`include "rgba_alpha_blend_assert.svh"

module rab_checker import rab_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input logic   out_ready,
  input field_t out_red,
  input field_t out_green,
  input field_t out_blue,
  input field_t out_alpha
);

  `RAB_ASSERT_NXT(a_valid_hold, out_valid && !out_ready, out_valid)
  `RAB_ASSERT_NXT(a_data_hold, out_valid && !out_ready, $stable(out_alpha) && $stable(out_red))
  `RAB_ASSERT_IMP(a_alpha_max, out_valid, out_alpha <= to_field(ONE))
  `RAB_ASSERT_IMP(a_zero_rgb, out_valid && out_alpha == '0, (out_red | out_green | out_blue) == '0)

endmodule

bind rgba_alpha_blend rab_checker u_rab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.out_red),
  .out_green (out_pix.out_green),
  .out_blue  (out_pix.out_blue),
  .out_alpha (out_pix.out_alpha)
);

>>> verif/rab_blend_checker.sv
`timescale 1ns / 100ps

module rab_blend_checker import rab_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  field_t           cfg_data,
  rab_in_if                in_mon,
  rab_out_if               out_mon,
  output int unsigned      fail_count,
  output int unsigned      pending
);

  typedef struct packed {
    field_t [3:0] base;
    field_t [3:0] top;
    logic         last;
  } pix_pair_t;

  typedef struct packed {
    field_t [3:0] rgba;
    logic         last;
  } pix_res_t;

  cfg_t      regs;
  pix_res_t  blend_q[$];
  pix_pair_t px;
  pix_res_t  got;
  pix_res_t  want;
  string     chan_name [4] = '{"red", "green", "blue", "alpha"};

  function automatic val_t sat_field(field_t v);
    return (v > ONE) ? ONE : val_t'(v);
  endfunction

  function automatic val_t sat_sum(logic [VAL_W:0] v);
    return (v > {1'b0, ONE}) ? ONE : v[VAL_W-1:0];
  endfunction

  function automatic val_t frac_mul(val_t a, val_t b);
    logic [2*VAL_W-1:0] p;
    p = a * b;
    return val_t'(p >> FRAC_BITS);
  endfunction

  function automatic val_t lerp(val_t t, val_t lo, val_t hi);
    return sat_sum({1'b0, frac_mul(ONE - t, lo)} + {1'b0, frac_mul(t, hi)});
  endfunction

  function automatic pix_res_t predict_blend(pix_pair_t p, cfg_t c);
    val_t           base [4];
    val_t           top  [4];
    val_t           res  [4];
    val_t           b;
    val_t           t;
    val_t           k;
    logic [VAL_W:0] acc;
    pix_res_t       r;
    b = sat_field(c.factor);
    for (int i = 0; i < 4; i++) begin
      base[i] = c.base_src ? sat_field(p.base[i]) : '0;
      top[i]  = c.top_src ? sat_field(p.top[i]) : sat_field(c.tint[i]);
    end
    t = frac_mul(top[CH_A], b);
    k = ONE - frac_mul(ONE - top[CH_A], b);
    case (c.mode)
      MODE_BLEND: begin
        for (int i = 0; i < 4; i++) res[i] = lerp(b, base[i], top[i]);
      end
      MODE_OVERLAY, MODE_OPAQUE, MODE_BLACK_GREEN, MODE_WHITE_GREEN: begin
        for (int i = 0; i < 3; i++) res[i] = lerp(t, base[i], top[i]);
        case (c.mode)
          MODE_OVERLAY: begin
            acc = {1'b0, base[CH_A]} + {1'b0, frac_mul(ONE - base[CH_A], t)};
          end
          MODE_OPAQUE: begin
            acc = {1'b0, frac_mul(base[CH_A], k)};
          end
          MODE_BLACK_GREEN: begin
            acc = {1'b0, frac_mul(frac_mul(ONE - base[CH_G], base[CH_A]), k)};
          end
          default: begin
            acc = {1'b0, frac_mul(frac_mul(base[CH_G], base[CH_A]), k)};
          end
        endcase
        res[CH_A] = sat_sum(acc);
      end
      default: begin
        res = base;
      end
    endcase
    if (res[CH_A] == '0) begin
      res[CH_R] = '0;
      res[CH_G] = '0;
      res[CH_B] = '0;
    end
    for (int i = 0; i < 4; i++) r.rgba[i] = field_t'(res[i]);
    r.last = p.last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.mode     = MODE_BLEND;
      regs.factor   = ONE;
      regs.base_src = 1'b1;
      regs.top_src  = 1'b1;
      regs.tint     = '0;
      blend_q.delete();
      fail_count    = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        px.base = {in_mon.base_alpha, in_mon.base_blue, in_mon.base_green, in_mon.base_red};
        px.top  = {in_mon.top_alpha, in_mon.top_blue, in_mon.top_green, in_mon.top_red};
        px.last = in_mon.in_last;
        blend_q.push_back(predict_blend(px, regs));
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:     regs.mode       = cfg_data[MODE_W-1:0];
          REG_FACTOR:   regs.factor     = cfg_data;
          REG_BASE_SRC: regs.base_src   = cfg_data[0];
          REG_TOP_SRC:  regs.top_src    = cfg_data[0];
          REG_TINT_R:   regs.tint[CH_R] = cfg_data;
          REG_TINT_G:   regs.tint[CH_G] = cfg_data;
          REG_TINT_B:   regs.tint[CH_B] = cfg_data;
          REG_TINT_A:   regs.tint[CH_A] = cfg_data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.rgba = {out_mon.out_alpha, out_mon.out_blue, out_mon.out_green, out_mon.out_red};
        got.last = out_mon.out_last;
        if (blend_q.size() == 0) begin
          report_mismatch("result transfer with no pixel pending");
        end else begin
          want = blend_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got.rgba[i] !== want.rgba[i]) begin
              report_mismatch($sformatf("%s got %0d want %0d",
                                        chan_name[i], got.rgba[i], want.rgba[i]));
            end
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
          end
        end
      end
    end
    pending = blend_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rab_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 24;
  localparam int PHASE_ITEMS  = 73;
  localparam field_t FULL     = 16'hFFFF;
  localparam field_t HALF     = 16'h4000;
  // codes the block treats as the zero mode
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef field_t [3:0] chan4_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  field_t           cfg_data;
  logic             sink_ready = 1'b1;
  int               sink_hold = 0;
  bit               calm = 1'b0;
  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      stall_cycles = 0;

  rab_in_if  in_pix ();
  rab_out_if out_pix ();

  assign out_pix.ready = sink_ready;

  rgba_alpha_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (in_pix),
    .out_pix   (out_pix)
  );

  rab_blend_checker blend_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_pix),
    .out_mon    (out_pix),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      sink_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      sink_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_hold  <= $urandom_range(0, 4);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_pix.valid && in_pix.ready) ||
        (out_pix.valid && out_pix.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic chan4_t quad(field_t r, field_t g, field_t b, field_t a);
    return {a, b, g, r};
  endfunction

  function automatic field_t rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE;
      2:       return field_t'($urandom_range(ONE + 1, FULL));
      3:       return field_t'($urandom_range(0, 15));
      default: return field_t'($urandom_range(0, ONE));
    endcase
  endfunction

  function automatic chan4_t rand_quad();
    return quad(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic send_pixel(input chan4_t base, input chan4_t top, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_pix.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.base_red   <= base[CH_R];
    in_pix.base_green <= base[CH_G];
    in_pix.base_blue  <= base[CH_B];
    in_pix.base_alpha <= base[CH_A];
    in_pix.top_red    <= top[CH_R];
    in_pix.top_green  <= top[CH_G];
    in_pix.top_blue   <= top[CH_B];
    in_pix.top_alpha  <= top[CH_A];
    in_pix.in_last    <= last;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_pix.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input field_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [MODE_W-1:0] mode, input field_t factor,
                               input logic base_src, input logic top_src,
                               input chan4_t tint);
    field_t junk;
    junk = field_t'($urandom);
    quiesce();
    write_reg(REG_MODE, {junk[FIELD_W-1:MODE_W], mode});
    write_reg(REG_FACTOR, factor);
    write_reg(REG_BASE_SRC, {junk[FIELD_W-1:1], base_src});
    write_reg(REG_TOP_SRC, {~junk[FIELD_W-1:1], top_src});
    write_reg(REG_TINT_R, tint[CH_R]);
    write_reg(REG_TINT_G, tint[CH_G]);
    write_reg(REG_TINT_B, tint[CH_B]);
    write_reg(REG_TINT_A, tint[CH_A]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    field_t            factor;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MODE;
    cfg_data          = '0;
    in_pix.valid      = 1'b0;
    in_pix.base_red   = '0;
    in_pix.base_green = '0;
    in_pix.base_blue  = '0;
    in_pix.base_alpha = '0;
    in_pix.top_red    = '0;
    in_pix.top_green  = '0;
    in_pix.top_blue   = '0;
    in_pix.top_alpha  = '0;
    in_pix.in_last    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: plain blend, factor 1.0
    send_pixel(quad(0, 0, 0, 0), quad(0, 0, 0, 0), 1'b0);
    send_pixel(quad(ONE, ONE, ONE, ONE), quad(ONE, ONE, ONE, ONE), 1'b1);
    send_pixel(quad(FULL, FULL, FULL, FULL), quad(FULL, FULL, FULL, FULL), 1'b0);
    send_pixel(quad(ONE, 0, ONE, ONE), quad(0, ONE, 0, 0), 1'b1);

    apply_setting(MODE_OVERLAY, HALF, 1'b1, 1'b1, quad(0, 0, 0, 0));
    send_pixel(quad(ONE, ONE, ONE, 0), quad(ONE, 0, ONE, 0), 1'b0);
    send_pixel(quad(16'h1234, 16'h4321, 16'h7FFF, ONE), quad(FULL, 0, ONE, FULL), 1'b1);
    send_pixel(quad(16'h7FFF, 1, 2, 3), quad(5, 6, 7, ONE), 1'b0);

    apply_setting(MODE_OPAQUE, ONE, 1'b1, 1'b1, quad(0, 0, 0, 0));
    send_pixel(quad(ONE, ONE, ONE, 0), quad(ONE, ONE, ONE, ONE), 1'b0);
    send_pixel(quad(100, 200, 300, ONE), quad(ONE, 0, ONE, 0), 1'b1);
    send_pixel(rand_quad(), rand_quad(), 1'b0);

    apply_setting(MODE_BLACK_GREEN, FULL, 1'b1, 1'b1, quad(0, 0, 0, 0));
    send_pixel(quad(ONE, 0, ONE, ONE), rand_quad(), 1'b0);
    send_pixel(quad(0, ONE, 0, ONE), rand_quad(), 1'b1);

    apply_setting(MODE_WHITE_GREEN, 0, 1'b1, 1'b1, quad(0, 0, 0, 0));
    send_pixel(quad(0, ONE, 0, ONE), rand_quad(), 1'b0);
    send_pixel(quad(ONE, 0, ONE, FULL), rand_quad(), 1'b1);

    apply_setting(MODE_ZERO, 16'h2000, 1'b1, 1'b1, quad(0, 0, 0, 0));
    send_pixel(quad(FULL, ONE, 1, 0), rand_quad(), 1'b0);
    send_pixel(rand_quad(), rand_quad(), 1'b1);

    // transparent base, tint top with channels above one
    apply_setting(MODE_SPARE_HI, HALF, 1'b0, 1'b0, quad(FULL, ONE, 16'h1111, FULL));
    send_pixel(rand_quad(), rand_quad(), 1'b0);
    send_pixel(rand_quad(), rand_quad(), 1'b1);

    apply_setting(MODE_BLEND, 16'h6000, 1'b0, 1'b0, quad(ONE, 16'h2222, FULL, ONE));
    send_pixel(rand_quad(), rand_quad(), 1'b0);
    send_pixel(rand_quad(), rand_quad(), 1'b1);

    apply_setting(MODE_SPARE_LO, ONE, 1'b1, 1'b0, quad(16'h0F0F, 0, ONE, HALF));
    send_pixel(rand_quad(), rand_quad(), 1'b0);

    apply_setting(MODE_OVERLAY, FULL, 1'b0, 1'b1, quad(0, 0, 0, 0));
    send_pixel(rand_quad(), rand_quad(), 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      mode = (ph < 16) ? MODE_W'(ph % 8) : MODE_W'($urandom_range(0, 7));
      case (ph)
        0:       factor = '0;
        1:       factor = ONE;
        2:       factor = FULL;
        default: factor = rand_chan();
      endcase
      apply_setting(mode, factor, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0,
                    rand_quad());
      calm = (ph >= PHASES - 2) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(rand_quad(), rand_quad(), 1'($urandom_range(0, 1)));
      end
    end

    quiesce();
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rab_pkg.sv
rtl/rab_if.sv
rtl/rab_prep.sv
rtl/rab_weight.sv
rtl/rab_mul.sv
rtl/rab_sum.sv
rtl/rgba_alpha_blend.sv
rtl/rab_checker.sv
verif/rab_blend_checker.sv
verif/testbench.sv
